// ===== rtl/bf_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, widths and constants of the 3x3 RGB box filter.
// No dependencies; the other files that use it refer to it by scoped names.
package bf_pkg;

    localparam int MaxSide    = 1024;
    localparam int CfgW       = 11;
    localparam int ChanW      = 16;
    localparam int OutPosW    = 10;
    localparam int WinDim     = 3;
    localparam int WinN       = WinDim * WinDim;
    localparam int ColSumW    = 18;
    localparam int SumW       = 20;
    localparam int RecipW     = 24;
    localparam int RecipShift = 23;
    localparam int ProdW      = SumW + RecipW;

    localparam logic [CfgW-1:0] CfgReset = 11'd1024;

    typedef logic [ChanW-1:0]   t_chan;
    typedef logic [OutPosW-1:0] t_pos;
    typedef logic [ColSumW-1:0] t_colsum;
    typedef logic [SumW-1:0]    t_sum;
    typedef logic [RecipW-1:0]  t_recip;
    typedef logic [ProdW-1:0]   t_prod;

    // ceil(2^23 / count); exact floor division for every sum that count can reach
    localparam t_recip Recip1 = 24'd8388608;
    localparam t_recip Recip2 = 24'd4194304;
    localparam t_recip Recip3 = 24'd2796203;
    localparam t_recip Recip4 = 24'd2097152;
    localparam t_recip Recip6 = 24'd1398102;
    localparam t_recip Recip9 = 24'd932068;

    typedef struct packed {
        t_chan red;
        t_chan green;
        t_chan blue;
    } t_pix;

    // one result to compute: position, first window row/column used, last flag
    typedef struct packed {
        t_pos       row;
        t_pos       col;
        logic [1:0] wr;
        logic [1:0] wc;
        logic       last;
    } t_job;

    typedef struct packed {
        t_colsum red;
        t_colsum green;
        t_colsum blue;
    } t_rgb_cs;

    typedef struct packed {
        t_sum red;
        t_sum green;
        t_sum blue;
    } t_rgb_sum;

    function automatic t_recip bf_recip(input logic [1:0] wr, input logic [1:0] wc);
        logic [1:0] rows;
        logic [1:0] cols;
        logic [3:0] cnt;
        t_recip     m;
        rows = 2'd3 - wr;
        cols = 2'd3 - wc;
        cnt  = {2'b00, rows} * {2'b00, cols};
        case (cnt)
            4'd9:    m = Recip9;
            4'd6:    m = Recip6;
            4'd4:    m = Recip4;
            4'd3:    m = Recip3;
            4'd2:    m = Recip2;
            default: m = Recip1;
        endcase
        return m;
    endfunction

endpackage

// ===== rtl/bf_ifs.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces: input pixel words and result words.
// Depends on bf_pkg for field widths.
interface bf_pix_if;
    logic                     valid;
    logic                     ready;
    logic [bf_pkg::ChanW-1:0] in_red;
    logic [bf_pkg::ChanW-1:0] in_green;
    logic [bf_pkg::ChanW-1:0] in_blue;

    modport source (output valid, in_red, in_green, in_blue, input ready);
    modport sink   (input valid, in_red, in_green, in_blue, output ready);
endinterface

interface bf_res_if;
    logic                       valid;
    logic                       ready;
    logic [bf_pkg::OutPosW-1:0] out_row;
    logic [bf_pkg::OutPosW-1:0] out_col;
    logic [bf_pkg::ChanW-1:0]   out_red;
    logic [bf_pkg::ChanW-1:0]   out_green;
    logic [bf_pkg::ChanW-1:0]   out_blue;
    logic                       run_end;

    modport source (output valid, out_row, out_col, out_red, out_green, out_blue, run_end,
                    input ready);
    modport sink   (input valid, out_row, out_col, out_red, out_green, out_blue, run_end,
                    output ready);
endinterface

// ===== rtl/box_filter_3x3_rgb.sv =====
`timescale 1ns / 1ps
// Top level of the 3x3 RGB box filter: front end and mean pipeline.
// Uses bf_pkg, bf_ifs, bf_front, bf_mean.
//
// Usage:
//   i_pix takes one RGB pixel word per valid/ready handshake, raster order,
//   over a square image whose side is written on i_cfg_we/i_cfg_data (write
//   only while idle; a write restarts the frame at row 0, column 0).
//   o_res delivers smoothed pixel words tagged with row and column; run_end
//   marks the last result caused by one input pixel. A pixel causes 0 to 4
//   results (more at the right edge and on the last row).
// Results pass the read stage, the job register and the mean pipeline.
// Throughput: one pixel per clock while each pixel causes at most one result
//   and o_res is taken; extra results hold the input, as all results share
//   one column-sum / reciprocal-multiply pipeline.
// Line stores are two RAMs of MAX_SIDE words, read at acceptance and written
//   when the read stage advances; they need no clearing after reset.
// Reset: side length 1024, position (0,0), window cleared.
// Stall: when o_res is not taken the pipeline fills and i_pix.ready drops;
//   nothing is lost or repeated.
module box_filter_3x3_rgb #(
    parameter int MAX_SIDE = bf_pkg::MaxSide
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [bf_pkg::CfgW-1:0] i_cfg_data,
    bf_pix_if.sink                  i_pix,
    bf_res_if.source                o_res
);

    logic         w_job_valid;
    logic         w_job_rdy;
    bf_pkg::t_job w_job;
    bf_pkg::t_pix w_win [bf_pkg::WinN];

    bf_front #(
        .MAX_SIDE (MAX_SIDE)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_pix       (i_pix),
        .i_job_rdy   (w_job_rdy),
        .o_job_valid (w_job_valid),
        .o_job       (w_job),
        .o_win       (w_win)
    );

    bf_mean u_mean (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (w_job_valid),
        .i_job       (w_job),
        .i_win       (w_win),
        .o_job_rdy   (w_job_rdy),
        .o_res       (o_res)
    );

endmodule

// ===== rtl/bf_ram.sv =====
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port with
// enable and registered read data. No dependencies.
module bf_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 1024
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic                                     i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/bf_front.sv =====
`timescale 1ns / 1ps
// Front end: raster position, two line-store RAMs, 3x3 window, job sequencer
// (one result per cycle while i_job_rdy is high). Uses bf_pkg, bf_ifs, bf_ram.
module bf_front #(
    parameter int MAX_SIDE = bf_pkg::MaxSide
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [bf_pkg::CfgW-1:0] i_cfg_data,
    bf_pix_if.sink                  i_pix,
    input  logic                    i_job_rdy,
    output logic                    o_job_valid,
    output bf_pkg::t_job            o_job,
    output bf_pkg::t_pix            o_win [bf_pkg::WinN]
);

    localparam int PW = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
    localparam int SW = ($clog2(MAX_SIDE + 1) > bf_pkg::CfgW) ?
                        $clog2(MAX_SIDE + 1) : bf_pkg::CfgW;

    // bit positions in the pending-job mask, in emission order
    localparam int JUpPrev  = 0;
    localparam int JUpCur   = 1;
    localparam int JRowPrev = 2;
    localparam int JRowCur  = 3;

    typedef logic [PW-1:0] t_addr;
    typedef logic [SW-1:0] t_side;

    typedef struct packed {
        logic c_ge1;
        logic c_ge2;
        logic c_last;
        logic r_ge1;
        logic r_ge2;
        logic r_last;
    } t_edge;

    logic [bf_pkg::CfgW-1:0] r_size;
    t_addr                   r_row;
    t_addr                   r_col;
    t_side                   w_side;
    t_edge                   w_edge;
    logic                    w_acc;
    bf_pkg::t_pix            w_px;

    logic                    r1_valid;
    bf_pkg::t_pix            r1_px;
    t_addr                   r1_row;
    t_addr                   r1_col;
    t_edge                   r1_edge;
    bf_pkg::t_pix            w_older_rd;
    bf_pkg::t_pix            w_prev_rd;

    bf_pkg::t_pix            r_win [bf_pkg::WinN];
    logic [3:0]              r_pend;
    t_addr                   r_jrow;
    t_addr                   r_jcol;
    t_edge                   r_jedge;
    logic [3:0]              w_sel;
    logic [3:0]              w_rest;
    logic [3:0]              n_jobs;
    logic                    w_free;
    logic                    w_s1_adv;
    logic                    w_up;
    logic                    w_left;

    // effective side: 0 acts as 1, oversize clamps to MAX_SIDE
    always_comb begin
        if (r_size == '0) begin
            w_side = t_side'(1);
        end else if (t_side'(r_size) > t_side'(MAX_SIDE)) begin
            w_side = t_side'(MAX_SIDE);
        end else begin
            w_side = t_side'(r_size);
        end
        w_edge.c_ge1  = (r_col != '0);
        w_edge.c_ge2  = (t_side'(r_col) >= t_side'(2));
        w_edge.c_last = ((t_side'(r_col) + t_side'(1)) == w_side);
        w_edge.r_ge1  = (r_row != '0);
        w_edge.r_ge2  = (t_side'(r_row) >= t_side'(2));
        w_edge.r_last = ((t_side'(r_row) + t_side'(1)) == w_side);
    end

    assign w_px.red   = i_pix.in_red;
    assign w_px.green = i_pix.in_green;
    assign w_px.blue  = i_pix.in_blue;

    assign w_sel    = r_pend & (~r_pend + 4'd1);
    assign w_rest   = r_pend & ~w_sel;
    assign w_free   = (r_pend == '0) || ((w_rest == '0) && i_job_rdy);
    assign w_s1_adv = r1_valid && w_free;

    assign i_pix.ready = !r1_valid || w_free;
    assign w_acc       = i_pix.valid && i_pix.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size <= bf_pkg::CfgReset;
            r_row  <= '0;
            r_col  <= '0;
        end else if (i_cfg_we) begin
            r_size <= i_cfg_data;
            r_row  <= '0;
            r_col  <= '0;
        end else if (w_acc) begin
            if (w_edge.c_last) begin
                r_col <= '0;
                r_row <= w_edge.r_last ? '0 : r_row + t_addr'(1);
            end else begin
                r_col <= r_col + t_addr'(1);
            end
        end
    end

    // read stage: line-store data arrives in the cycle after acceptance
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (w_acc) begin
            r1_valid <= 1'b1;
        end else if (w_s1_adv) begin
            r1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r1_px   <= w_px;
            r1_row  <= r_row;
            r1_col  <= r_col;
            r1_edge <= w_edge;
        end
    end

    // older[c] <= previous[c], previous[c] <= pixel
    bf_ram #(
        .WIDTH ($bits(bf_pkg::t_pix)),
        .DEPTH (MAX_SIDE)
    ) u_older (
        .i_clk   (i_clk),
        .i_we    (w_s1_adv),
        .i_waddr (r1_col),
        .i_wdata (w_prev_rd),
        .i_re    (w_acc),
        .i_raddr (r_col),
        .o_rdata (w_older_rd)
    );

    bf_ram #(
        .WIDTH ($bits(bf_pkg::t_pix)),
        .DEPTH (MAX_SIDE)
    ) u_prev (
        .i_clk   (i_clk),
        .i_we    (w_s1_adv),
        .i_waddr (r1_col),
        .i_wdata (r1_px),
        .i_re    (w_acc),
        .i_raddr (r_col),
        .o_rdata (w_prev_rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < bf_pkg::WinN; i++) begin
                r_win[i] <= '0;
            end
        end else if (w_s1_adv) begin
            for (int a = 0; a < bf_pkg::WinDim; a++) begin
                r_win[a*bf_pkg::WinDim]     <= r_win[a*bf_pkg::WinDim + 1];
                r_win[a*bf_pkg::WinDim + 1] <= r_win[a*bf_pkg::WinDim + 2];
            end
            r_win[2] <= w_older_rd;
            r_win[5] <= w_prev_rd;
            r_win[8] <= r1_px;
        end
    end

    always_comb begin
        n_jobs[JUpPrev]  = r1_edge.r_ge1 && r1_edge.c_ge1;
        n_jobs[JUpCur]   = r1_edge.r_ge1 && r1_edge.c_last;
        n_jobs[JRowPrev] = r1_edge.r_last && r1_edge.c_ge1;
        n_jobs[JRowCur]  = r1_edge.r_last && r1_edge.c_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
        end else if (w_s1_adv) begin
            r_pend <= n_jobs;
        end else if ((r_pend != '0) && i_job_rdy) begin
            r_pend <= w_rest;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_adv) begin
            r_jrow  <= r1_row;
            r_jcol  <= r1_col;
            r_jedge <= r1_edge;
        end
    end

    // row above / column to the left of the pixel position
    assign w_up   = w_sel[JUpPrev] || w_sel[JUpCur];
    assign w_left = w_sel[JUpPrev] || w_sel[JRowPrev];

    always_comb begin
        o_job.row  = w_up   ? bf_pkg::t_pos'(r_jrow - t_addr'(1)) : bf_pkg::t_pos'(r_jrow);
        o_job.col  = w_left ? bf_pkg::t_pos'(r_jcol - t_addr'(1)) : bf_pkg::t_pos'(r_jcol);
        if (w_up) begin
            o_job.wr = r_jedge.r_ge2 ? 2'd0 : 2'd1;
        end else begin
            o_job.wr = r_jedge.r_ge1 ? 2'd1 : 2'd2;
        end
        if (w_left) begin
            o_job.wc = r_jedge.c_ge2 ? 2'd0 : 2'd1;
        end else begin
            o_job.wc = r_jedge.c_ge1 ? 2'd1 : 2'd2;
        end
        o_job.last = (w_rest == '0);
    end

    assign o_job_valid = (r_pend != '0);
    assign o_win       = r_win;

endmodule

// ===== rtl/bf_mean.sv =====
`timescale 1ns / 1ps
// Mean pipeline: column sums, window sum, reciprocal multiply; the last
// stage is the output register. Uses bf_pkg and bf_res_if.
module bf_mean (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_job_valid,
    input  bf_pkg::t_job i_job,
    input  bf_pkg::t_pix i_win [bf_pkg::WinN],
    output logic         o_job_rdy,
    bf_res_if.source     o_res
);

    typedef struct packed {
        bf_pkg::t_prod red;
        bf_pkg::t_prod green;
        bf_pkg::t_prod blue;
    } t_rgb_prod;

    typedef struct packed {
        bf_pkg::t_pos row;
        bf_pkg::t_pos col;
        logic         last;
    } t_tag;

    logic            w_en3;
    logic            w_en4;
    logic            w_en5;

    logic            r3_valid;
    bf_pkg::t_rgb_cs r3_cs [bf_pkg::WinDim];
    logic [1:0]      r3_wr;
    logic [1:0]      r3_wc;
    t_tag            r3_tag;
    bf_pkg::t_rgb_cs n_cs [bf_pkg::WinDim];

    logic            r4_valid;
    bf_pkg::t_rgb_sum r4_sum;
    bf_pkg::t_recip  r4_recip;
    t_tag            r4_tag;
    bf_pkg::t_rgb_sum n_sum;

    logic            r5_valid;
    t_rgb_prod       r5_prod;
    t_tag            r5_tag;
    t_rgb_prod       n_prod;

    function automatic bf_pkg::t_colsum col_sum(
        input bf_pkg::t_chan top,
        input bf_pkg::t_chan mid,
        input bf_pkg::t_chan bot,
        input logic          use_top,
        input logic          use_mid,
        input logic          use_col
    );
        bf_pkg::t_colsum s;
        s = bf_pkg::t_colsum'(bot);
        if (use_mid) begin
            s = s + bf_pkg::t_colsum'(mid);
        end
        if (use_top) begin
            s = s + bf_pkg::t_colsum'(top);
        end
        return use_col ? s : '0;
    endfunction

    assign w_en5     = !r5_valid || o_res.ready;
    assign w_en4     = !r4_valid || w_en5;
    assign w_en3     = !r3_valid || w_en4;
    assign o_job_rdy = w_en3;

    always_comb begin
        for (int k = 0; k < bf_pkg::WinDim; k++) begin
            n_cs[k].red   = col_sum(i_win[k].red, i_win[k+3].red, i_win[k+6].red,
                                    i_job.wr == 2'd0, i_job.wr != 2'd2,
                                    2'(k) >= i_job.wc);
            n_cs[k].green = col_sum(i_win[k].green, i_win[k+3].green, i_win[k+6].green,
                                    i_job.wr == 2'd0, i_job.wr != 2'd2,
                                    2'(k) >= i_job.wc);
            n_cs[k].blue  = col_sum(i_win[k].blue, i_win[k+3].blue, i_win[k+6].blue,
                                    i_job.wr == 2'd0, i_job.wr != 2'd2,
                                    2'(k) >= i_job.wc);
        end
    end

    always_comb begin
        n_sum.red   = bf_pkg::t_sum'(r3_cs[0].red) + bf_pkg::t_sum'(r3_cs[1].red)
                    + bf_pkg::t_sum'(r3_cs[2].red);
        n_sum.green = bf_pkg::t_sum'(r3_cs[0].green) + bf_pkg::t_sum'(r3_cs[1].green)
                    + bf_pkg::t_sum'(r3_cs[2].green);
        n_sum.blue  = bf_pkg::t_sum'(r3_cs[0].blue) + bf_pkg::t_sum'(r3_cs[1].blue)
                    + bf_pkg::t_sum'(r3_cs[2].blue);
    end

    always_comb begin
        n_prod.red   = bf_pkg::t_prod'(r4_sum.red) * bf_pkg::t_prod'(r4_recip);
        n_prod.green = bf_pkg::t_prod'(r4_sum.green) * bf_pkg::t_prod'(r4_recip);
        n_prod.blue  = bf_pkg::t_prod'(r4_sum.blue) * bf_pkg::t_prod'(r4_recip);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
            r4_valid <= 1'b0;
            r5_valid <= 1'b0;
        end else begin
            if (w_en3) begin
                r3_valid <= i_job_valid;
            end
            if (w_en4) begin
                r4_valid <= r3_valid;
            end
            if (w_en5) begin
                r5_valid <= r4_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en3) begin
            r3_cs       <= n_cs;
            r3_wr       <= i_job.wr;
            r3_wc       <= i_job.wc;
            r3_tag.row  <= i_job.row;
            r3_tag.col  <= i_job.col;
            r3_tag.last <= i_job.last;
        end
        if (w_en4) begin
            r4_sum   <= n_sum;
            r4_recip <= bf_pkg::bf_recip(r3_wr, r3_wc);
            r4_tag   <= r3_tag;
        end
        if (w_en5) begin
            r5_prod <= n_prod;
            r5_tag  <= r4_tag;
        end
    end

    assign o_res.valid     = r5_valid;
    assign o_res.out_row   = r5_tag.row;
    assign o_res.out_col   = r5_tag.col;
    assign o_res.out_red   = r5_prod.red[bf_pkg::RecipShift +: bf_pkg::ChanW];
    assign o_res.out_green = r5_prod.green[bf_pkg::RecipShift +: bf_pkg::ChanW];
    assign o_res.out_blue  = r5_prod.blue[bf_pkg::RecipShift +: bf_pkg::ChanW];
    assign o_res.run_end   = r5_tag.last;

endmodule

// ===== dv/box_filter_3x3_rgb_tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for box_filter_3x3_rgb: directed table, oversize side, random frames.
// Depends on bf_pkg, bf_ifs and the filter RTL; each result word is checked against a local model.
module box_filter_3x3_rgb_tb;

    localparam int ClkHalf    = 10;
    localparam int RstCycles  = 6;
    localparam int IdleMax    = 15;
    localparam int DrainWait  = 8;
    localparam int StallLimit = 2000;
    localparam int RandItems  = 300;
    localparam int TopItems   = 8;

    localparam logic [bf_pkg::CfgW-1:0] CfgTop = '1;

    typedef struct packed {
        bf_pkg::t_pos  row;
        bf_pkg::t_pos  col;
        bf_pkg::t_chan red;
        bf_pkg::t_chan green;
        bf_pkg::t_chan blue;
        logic          last;
    } t_smooth;

    typedef enum logic {STEP_CFG, STEP_PIX} t_step_kind;

    typedef struct packed {
        t_step_kind              kind;
        logic [bf_pkg::CfgW-1:0] side;
        bf_pkg::t_pix            px;
        logic [2:0]              n_res;
        logic                    chk_mean;
        bf_pkg::t_pix            mean;
    } t_step;

    localparam logic [2:0] AnyCount = 3'd7;
    localparam int PlanLen = 23;

    // n_res and mean are typed only where they are obvious
    localparam t_step Plan [PlanLen] = '{
        '{STEP_PIX, 11'd0, 48'hFFFF_0000_AAAA, 3'd0, 1'b0, 48'h0},
        '{STEP_PIX, 11'd0, 48'h5555_FFFF_0000, 3'd0, 1'b0, 48'h0},
        '{STEP_CFG, 11'd0, 48'h0, AnyCount, 1'b0, 48'h0},
        '{STEP_PIX, 11'd0, 48'hFFFF_FFFF_FFFF, 3'd1, 1'b1, 48'hFFFF_FFFF_FFFF},
        '{STEP_PIX, 11'd0, 48'h0000_0000_0000, 3'd1, 1'b1, 48'h0000_0000_0000},
        '{STEP_PIX, 11'd0, 48'h1234_5678_9ABC, 3'd1, 1'b1, 48'h1234_5678_9ABC},
        '{STEP_CFG, 11'd1, 48'h0, AnyCount, 1'b0, 48'h0},
        '{STEP_PIX, 11'd0, 48'h8000_0001_7FFF, 3'd1, 1'b1, 48'h8000_0001_7FFF},
        '{STEP_CFG, 11'd2, 48'h0, AnyCount, 1'b0, 48'h0},
        '{STEP_PIX, 11'd0, 48'hFFFF_FFFF_FFFF, 3'd0, 1'b0, 48'h0},
        '{STEP_PIX, 11'd0, 48'hFFFF_FFFF_FFFF, 3'd0, 1'b0, 48'h0},
        '{STEP_PIX, 11'd0, 48'hFFFF_FFFF_FFFF, 3'd0, 1'b0, 48'h0},
        '{STEP_PIX, 11'd0, 48'hFFFF_FFFF_FFFF, 3'd4, 1'b1, 48'hFFFF_FFFF_FFFF},
        '{STEP_CFG, 11'd3, 48'h0, AnyCount, 1'b0, 48'h0},
        '{STEP_PIX, 11'd0, 48'hFFFF_0001_8000, 3'd0, 1'b0, 48'h0},
        '{STEP_PIX, 11'd0, 48'h0000_FFFE_7FFF, 3'd0, 1'b0, 48'h0},
        '{STEP_PIX, 11'd0, 48'hFFFF_FFFF_0003, 3'd0, 1'b0, 48'h0},
        '{STEP_PIX, 11'd0, 48'h0001_0000_FFFF, 3'd0, 1'b0, 48'h0},
        '{STEP_PIX, 11'd0, 48'hFFFF_FFFF_FFFF, 3'd1, 1'b0, 48'h0},
        '{STEP_PIX, 11'd0, 48'h0000_0002_1111, 3'd2, 1'b0, 48'h0},
        '{STEP_PIX, 11'd0, 48'hFFFF_0000_FFFF, 3'd0, 1'b0, 48'h0},
        '{STEP_PIX, 11'd0, 48'h0007_FFFF_0000, 3'd2, 1'b0, 48'h0},
        '{STEP_PIX, 11'd0, 48'hFFFF_FFFF_0005, 3'd4, 1'b0, 48'h0}
    };

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_cfg_we;
    logic [bf_pkg::CfgW-1:0] i_cfg_data;

    bf_pix_if pix_if ();
    bf_res_if res_if ();

    box_filter_3x3_rgb u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_pix      (pix_if),
        .o_res      (res_if)
    );

    // model state
    bf_pkg::t_pix            line_old  [bf_pkg::MaxSide];
    bf_pkg::t_pix            line_prev [bf_pkg::MaxSide];
    bf_pkg::t_pix            win       [bf_pkg::WinN];
    int                      cur_row;
    int                      cur_col;
    logic [bf_pkg::CfgW-1:0] side_cfg;

    t_smooth smooth_q [$];
    t_smooth fresh [4];
    int      fresh_n;
    int      errors;
    int      quiet_cycles;
    bit      idle_on;

    initial begin
        i_clk = 1'b0;
        forever #ClkHalf i_clk = ~i_clk;
    end

    function automatic t_smooth window_mean(input int row, input int col,
                                            input int wr, input int wc);
        t_smooth     s;
        int unsigned sr;
        int unsigned sg;
        int unsigned sb;
        int unsigned cnt;
        int          a;
        int          b;
        sr  = 0;
        sg  = 0;
        sb  = 0;
        cnt = 0;
        for (a = wr; a < bf_pkg::WinDim; a++) begin
            for (b = wc; b < bf_pkg::WinDim; b++) begin
                sr += win[a*bf_pkg::WinDim + b].red;
                sg += win[a*bf_pkg::WinDim + b].green;
                sb += win[a*bf_pkg::WinDim + b].blue;
                cnt++;
            end
        end
        s.row   = bf_pkg::t_pos'(row);
        s.col   = bf_pkg::t_pos'(col);
        s.red   = bf_pkg::t_chan'(sr / cnt);
        s.green = bf_pkg::t_chan'(sg / cnt);
        s.blue  = bf_pkg::t_chan'(sb / cnt);
        s.last  = 1'b0;
        return s;
    endfunction

    // shift one pixel into the window and queue every output it completes
    function automatic void filter_pixel(input bf_pkg::t_pix px);
        int           n;
        int           r;
        int           c;
        int           a;
        int           wr;
        bf_pkg::t_pix up2;
        bf_pkg::t_pix up1;
        n = int'(side_cfg);
        if (n < 1) n = 1;
        if (n > bf_pkg::MaxSide) n = bf_pkg::MaxSide;
        r = cur_row;
        c = cur_col;
        if (r >= n) r = 0;
        if (c >= n) c = 0;

        up2          = line_old[c];
        up1          = line_prev[c];
        line_old[c]  = up1;
        line_prev[c] = px;
        for (a = 0; a < bf_pkg::WinDim; a++) begin
            win[a*bf_pkg::WinDim]     = win[a*bf_pkg::WinDim + 1];
            win[a*bf_pkg::WinDim + 1] = win[a*bf_pkg::WinDim + 2];
        end
        win[2] = up2;
        win[5] = up1;
        win[8] = px;

        fresh_n = 0;
        if (r >= 1) begin
            wr = (r >= 2) ? 0 : 1;
            if (c >= 1) begin
                fresh[fresh_n] = window_mean(r - 1, c - 1, wr, (c >= 2) ? 0 : 1);
                fresh_n++;
            end
            if (c == n - 1) begin
                fresh[fresh_n] = window_mean(r - 1, c, wr, (c >= 1) ? 1 : 2);
                fresh_n++;
            end
        end
        if (r == n - 1) begin
            wr = (r >= 1) ? 1 : 2;
            if (c >= 1) begin
                fresh[fresh_n] = window_mean(r, c - 1, wr, (c >= 2) ? 0 : 1);
                fresh_n++;
            end
            if (c == n - 1) begin
                fresh[fresh_n] = window_mean(r, c, wr, (c >= 1) ? 1 : 2);
                fresh_n++;
            end
        end
        if (fresh_n > 0) fresh[fresh_n - 1].last = 1'b1;
        for (a = 0; a < fresh_n; a++) smooth_q.push_back(fresh[a]);

        if (c + 1 >= n) begin
            cur_col = 0;
            cur_row = (r + 1 >= n) ? 0 : r + 1;
        end else begin
            cur_col = c + 1;
            cur_row = r;
        end
    endfunction

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endfunction

    function automatic bf_pkg::t_chan pick_chan();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            default: return bf_pkg::t_chan'($urandom);
        endcase
    endfunction

    task automatic drain_results();
        pix_if.valid = 1'b0;
        while (smooth_q.size() != 0) @(negedge i_clk);
    endtask

    task automatic write_side(input logic [bf_pkg::CfgW-1:0] v);
        drain_results();
        repeat (DrainWait) @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_data = v;
        @(posedge i_clk);
        side_cfg = v;
        cur_row  = 0;
        cur_col  = 0;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic push_pixel(input bf_pkg::t_pix px);
        int gap;
        gap = idle_on ? $urandom_range(0, IdleMax) : 0;
        if (gap > 0) begin
            pix_if.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        pix_if.valid    = 1'b1;
        pix_if.in_red   = px.red;
        pix_if.in_green = px.green;
        pix_if.in_blue  = px.blue;
        do @(posedge i_clk); while (pix_if.ready !== 1'b1);
        filter_pixel(px);
        @(negedge i_clk);
    endtask

    // result sink with random stalls
    initial begin : sink
        int stall;
        res_if.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            stall = idle_on ? $urandom_range(0, IdleMax) : 0;
            if (stall > 0) begin
                res_if.ready = 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            res_if.ready = 1'b1;
            do @(posedge i_clk); while (res_if.valid !== 1'b1);
            @(negedge i_clk);
        end
    end

    always @(posedge i_clk) begin : monitor
        t_smooth want;
        if (i_rst_n) begin
            if (res_if.valid && res_if.ready) begin
                quiet_cycles = 0;
                if (smooth_q.size() == 0) begin
                    $error("unexpected result word: row %0d col %0d",
                           res_if.out_row, res_if.out_col);
                    errors++;
                end else begin
                    want = smooth_q.pop_front();
                    check_field("out_row",   want.row,   res_if.out_row);
                    check_field("out_col",   want.col,   res_if.out_col);
                    check_field("out_red",   want.red,   res_if.out_red);
                    check_field("out_green", want.green, res_if.out_green);
                    check_field("out_blue",  want.blue,  res_if.out_blue);
                    check_field("run_end",   want.last,  res_if.run_end);
                end
            end else if (pix_if.valid && pix_if.ready) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
                if (quiet_cycles >= StallLimit) begin
                    $display("CHECK FAILED");
                    $finish;
                end
            end
        end
    end

    initial begin : stimulus
        int                      i;
        int                      j;
        int                      k;
        int                      side;
        int                      count;
        int                      total;
        bit                      paused;
        logic [bf_pkg::CfgW-1:0] cfg_v;
        bf_pkg::t_pix            px;

        errors       = 0;
        quiet_cycles = 0;
        idle_on      = 1'b1;
        side_cfg     = bf_pkg::CfgReset;
        cur_row      = 0;
        cur_col      = 0;
        for (i = 0; i < bf_pkg::MaxSide; i++) begin
            line_old[i]  = '0;
            line_prev[i] = '0;
        end
        for (i = 0; i < bf_pkg::WinN; i++) win[i] = '0;

        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_data      = bf_pkg::CfgReset;
        pix_if.valid    = 1'b0;
        pix_if.in_red   = '0;
        pix_if.in_green = '0;
        pix_if.in_blue  = '0;
        repeat (RstCycles) @(negedge i_clk);
        i_rst_n = 1'b1;

        for (i = 0; i < PlanLen; i++) begin
            if (Plan[i].kind == STEP_CFG) begin
                write_side(Plan[i].side);
            end else begin
                push_pixel(Plan[i].px);
                if (Plan[i].n_res != AnyCount && fresh_n != int'(Plan[i].n_res)) begin
                    $error("step %0d result count: expected %0d, got %0d",
                           i, Plan[i].n_res, fresh_n);
                    errors++;
                end
                if (Plan[i].chk_mean) begin
                    for (j = 0; j < fresh_n; j++) begin
                        if ({fresh[j].red, fresh[j].green, fresh[j].blue} != Plan[i].mean) begin
                            $error("step %0d mean: expected %h, got %h", i, Plan[i].mean,
                                   {fresh[j].red, fresh[j].green, fresh[j].blue});
                            errors++;
                        end
                    end
                end
            end
        end

        // oversize side clamps to the full line width
        write_side(CfgTop);
        for (k = 0; k < TopItems; k++) begin
            px = '{pick_chan(), pick_chan(), pick_chan()};
            push_pixel(px);
        end

        total  = 0;
        paused = 1'b0;
        while (total < RandItems) begin
            idle_on = ($urandom_range(0, 3) != 0);
            side    = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 24)
                                                  : $urandom_range(1, 12);
            cfg_v = side[bf_pkg::CfgW-1:0];
            if (side == 1 && $urandom_range(0, 1) == 1) cfg_v = '0;
            write_side(cfg_v);
            if (side > 12) count = $urandom_range(side * 2, side * 4);
            else if ($urandom_range(0, 3) == 0) count = $urandom_range(1, side * side);
            else count = side * side * $urandom_range(1, 2);
            if (count > RandItems - total) count = RandItems - total;
            for (k = 0; k < count; k++) begin
                if (k == count / 2 && (!paused || $urandom_range(0, 3) == 0)) begin
                    drain_results();
                    paused = 1'b1;
                end
                px = '{pick_chan(), pick_chan(), pick_chan()};
                push_pixel(px);
            end
            total += count;
        end

        drain_results();
        repeat (DrainWait) @(negedge i_clk);
        if (errors == 0 && smooth_q.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/bf_pkg.sv
rtl/bf_ifs.sv
rtl/bf_ram.sv
rtl/bf_front.sv
rtl/bf_mean.sv
rtl/box_filter_3x3_rgb.sv
dv/box_filter_3x3_rgb_tb.sv
